// File: rtl/core/vfs_pkg.sv
// Shared constants for the valve feedback supervisor: valve kind codes,
// reported state codes, configuration register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package vfs_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int NOW_W         = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int KIND_W        = 3;
  localparam int STATE_W       = 3;
  localparam int CMD_W         = 2;

  // valve kinds
  localparam logic [KIND_W-1:0] KIND_ONE_OUT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TWO_OUT   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OUT_FB    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_OUT_2FB   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_2OUT_2FB  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_MIXPROOF  = 3'd5;

  // reported valve state
  localparam logic [STATE_W-1:0] ST_CLOSED = 3'd0;
  localparam logic [STATE_W-1:0] ST_OPEN   = 3'd1;
  localparam logic [STATE_W-1:0] ST_UPPER  = 3'd2;
  localparam logic [STATE_W-1:0] ST_LOWER  = 3'd3;
  localparam logic [STATE_W-1:0] ST_FAULT  = 3'd4;

  // commands
  localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_OPEN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UPPER = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LOWER = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VALVE_KIND  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_POLARITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_TIME = 2'd2;

  localparam logic [CFG_DATA_W-1:0] SWITCH_TIME_RST = 16'd1000;

endpackage

// File: rtl/core/valve_feedback_supervisor_core.sv
// Valve feedback supervisor top level: command handling, feedback check and
// switch timeout, one result register on the output side.
// Depends on vfs_pkg.
`timescale 1ns / 1ps

// Usage:
//  - Input channel (in_valid/in_ready): one word per I/O scan, carrying an
//    optional command, the two feedback bits and the millisecond timestamp.
//  - Output channel (out_valid/out_ready): one word per input word, with the
//    reported valve state and the drive bits to put on the coils.
//  - Config port (cfg_we/cfg_index/cfg_wdata): valve kind, feedback polarity
//    and switch time; write only while no word is in flight.
//  - A word taken at an edge shows on the output after that edge. Throughput
//    is one word per cycle when not stalled; the command update, feedback
//    match and timeout compare all sit between the input ports and the result
//    register, and the held coil bits and start time update at the same edge.
//  - in_ready is high whenever the result register is empty or being drained
//    in the same cycle, so a stalled receiver holds off at most one word.
//  - Synchronous reset clears the coils, the start time and the output valid,
//    and loads the config defaults (one output, inverted feedback, 1000 ms).
module valve_feedback_supervisor_core
  import vfs_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd_valid,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic                  in_fb_first,
  input  logic                  in_fb_second,
  input  logic [NOW_W-1:0]      in_now_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATE_W-1:0]    out_valve_state,
  output logic                  out_drive_main,
  output logic                  out_drive_second,
  output logic                  out_drive_upper,
  output logic                  out_drive_lower
);

  localparam int NOW_USE = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;

  logic [KIND_W-1:0]     kind_r;
  logic                  pol_r;
  logic [CFG_DATA_W-1:0] swtime_r;

  logic                  coil_main_r, coil_main_nxt;
  logic                  coil_second_r, coil_second_nxt;
  logic                  seat_upper_r, seat_upper_nxt;
  logic                  seat_lower_r, seat_lower_nxt;
  logic [TIME_BITS-1:0]  start_r, start_nxt;

  logic                  out_valid_r;
  logic [STATE_W-1:0]    state_r, state_nxt;
  logic                  drv_main_r, drv_second_r, drv_upper_r, drv_lower_r;

  logic [TIME_BITS-1:0]  time_now;
  logic                  accept;

  assign time_now = TIME_BITS'(in_now_ms[NOW_USE-1:0]);
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic                 cm, cs, su, sl, on, tgt, match, tout;
    logic [TIME_BITS-1:0] st, diff;
    cm    = coil_main_r;
    cs    = coil_second_r;
    su    = seat_upper_r;
    sl    = seat_lower_r;
    st    = start_r;
    on    = (in_cmd != CMD_CLOSE);
    tgt   = (in_cmd == CMD_OPEN);
    match = 1'b0;

    // command first, then evaluate against the updated drives
    if (in_cmd_valid) begin
      case (kind_r) inside
        KIND_ONE_OUT: begin
          cm = on;
        end
        KIND_TWO_OUT: begin
          cm = !on;
          cs = on;
        end
        KIND_OUT_FB, KIND_OUT_2FB: begin
          if (cm != on) begin
            st = time_now;
            cm = on;
          end
        end
        KIND_2OUT_2FB: begin
          if (on && !cs) begin
            st = time_now;
            cm = 1'b0;
            cs = 1'b1;
          end else if (!on && !cm) begin
            st = time_now;
            cm = 1'b1;
            cs = 1'b0;
          end
        end
        KIND_MIXPROOF: begin
          if (cm != tgt) begin
            st = time_now;
            cm = tgt;
          end
          su = (in_cmd == CMD_UPPER);
          sl = (in_cmd == CMD_LOWER);
        end
        default: begin
        end
      endcase
    end

    diff = time_now - st;
    tout = (diff > TIME_BITS'(swtime_r));

    case (kind_r) inside
      KIND_ONE_OUT: begin
        state_nxt = STATE_W'(cm);
      end
      KIND_TWO_OUT: begin
        state_nxt = (cm == cs) ? ST_FAULT : STATE_W'(cs);
      end
      KIND_OUT_FB: begin
        match = pol_r ? (in_fb_first == cm) : (in_fb_first != cm);
        if (match) state_nxt = STATE_W'(cm);
        else       state_nxt = tout ? ST_FAULT : STATE_W'(!cm);
      end
      KIND_OUT_2FB, KIND_MIXPROOF: begin
        match = (!cm && in_fb_first && !in_fb_second) ||
                (cm && in_fb_second && !in_fb_first);
        if (match) begin
          if (kind_r == KIND_MIXPROOF && !cm && su)      state_nxt = ST_UPPER;
          else if (kind_r == KIND_MIXPROOF && !cm && sl) state_nxt = ST_LOWER;
          else                                           state_nxt = STATE_W'(cm);
        end else begin
          state_nxt = tout ? ST_FAULT : STATE_W'(cm);
        end
      end
      KIND_2OUT_2FB: begin
        match = (in_fb_first == cm) && (in_fb_second == cs);
        if (match) state_nxt = STATE_W'(cs);
        else       state_nxt = tout ? ST_FAULT : STATE_W'(cs);
      end
      default: begin
        state_nxt = ST_CLOSED;
      end
    endcase

    if (match) st = time_now;

    coil_main_nxt   = cm;
    coil_second_nxt = cs;
    seat_upper_nxt  = su;
    seat_lower_nxt  = sl;
    start_nxt       = st;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= KIND_ONE_OUT;
      pol_r    <= 1'b0;
      swtime_r <= SWITCH_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VALVE_KIND:  kind_r   <= cfg_wdata[KIND_W-1:0];
        CFG_FB_POLARITY: pol_r    <= cfg_wdata[0];
        CFG_SWITCH_TIME: swtime_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // held valve state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coil_main_r   <= 1'b0;
      coil_second_r <= 1'b0;
      seat_upper_r  <= 1'b0;
      seat_lower_r  <= 1'b0;
      start_r       <= '0;
    end else if (accept) begin
      coil_main_r   <= coil_main_nxt;
      coil_second_r <= coil_second_nxt;
      seat_upper_r  <= seat_upper_nxt;
      seat_lower_r  <= seat_lower_nxt;
      start_r       <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result word, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      state_r      <= state_nxt;
      drv_main_r   <= (kind_r <= KIND_MIXPROOF) && coil_main_nxt;
      drv_second_r <= (kind_r == KIND_TWO_OUT || kind_r == KIND_2OUT_2FB) &&
                      coil_second_nxt;
      drv_upper_r  <= (kind_r == KIND_MIXPROOF) && seat_upper_nxt;
      drv_lower_r  <= (kind_r == KIND_MIXPROOF) && seat_lower_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_valve_state  = state_r;
  assign out_drive_main   = drv_main_r;
  assign out_drive_second = drv_second_r;
  assign out_drive_upper  = drv_upper_r;
  assign out_drive_lower  = drv_lower_r;

endmodule

// File: rtl/core/vfs_checker.sv
// Port-level checks for the valve feedback supervisor, bound to the top level.
// Depends on vfs_pkg and valve_feedback_supervisor_core.
`timescale 1ns / 1ps

module vfs_checker
  import vfs_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [STATE_W-1:0] out_valve_state,
  input logic               out_drive_main,
  input logic               out_drive_second,
  input logic               out_drive_upper,
  input logic               out_drive_lower
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_valve_state) &&
      $stable(out_drive_main) && $stable(out_drive_second) &&
      $stable(out_drive_upper) && $stable(out_drive_lower))
    else $error("result word changed while stalled");

  // every accepted word yields a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  // single result slot: a stalled result blocks the input
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result register full");

  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_valve_state <= ST_FAULT)
    else $error("valve state code out of range");

  a_seat_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_drive_upper && out_drive_lower))
    else $error("both seat lifts driven");

endmodule

bind valve_feedback_supervisor_core vfs_checker u_vfs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_valve_state  (out_valve_state),
  .out_drive_main   (out_drive_main),
  .out_drive_second (out_drive_second),
  .out_drive_upper  (out_drive_upper),
  .out_drive_lower  (out_drive_lower)
);

// File: sim/tb_valve_feedback_supervisor_core.sv
// Testbench for valve_feedback_supervisor_core: directed and random command/feedback
// words, checked against a shadow of the valve state kept in a small class.
// Depends on vfs_pkg and the core RTL.
`timescale 1ns / 1ps

import vfs_pkg::*;

typedef struct packed {
  logic [STATE_W-1:0] state;
  logic               drive_main;
  logic               drive_second;
  logic               drive_upper;
  logic               drive_lower;
} valve_word_t;

// Shadow of the coils, seats, switch start time and settings; one word due per input word.
class valve_shadow;
  logic [KIND_W-1:0]     kind;
  logic                  polarity;
  logic [CFG_DATA_W-1:0] switch_ms;
  bit                    coil_main, coil_second, seat_upper, seat_lower;
  bit [NOW_W-1:0]        start_ms;
  valve_word_t           due_words[$];
  int                    words_taken, results_checked, faults_seen, errors;

  function new();
    kind            = KIND_ONE_OUT;
    polarity        = 1'b0;
    switch_ms       = SWITCH_TIME_RST;
    words_taken     = 0;
    results_checked = 0;
    faults_seen     = 0;
    errors          = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_VALVE_KIND:  kind = data[KIND_W-1:0];
      CFG_FB_POLARITY: polarity = data[0];
      CFG_SWITCH_TIME: switch_ms = data;
      default: ;
    endcase
  endfunction

  // elapsed time wraps modulo 2^32
  function bit expired(bit [NOW_W-1:0] now);
    bit [NOW_W-1:0] diff;
    diff = now - start_ms;
    return diff > switch_ms;
  endfunction

  function logic [STATE_W-1:0] position(bit on);
    return on ? ST_OPEN : ST_CLOSED;
  endfunction

  function void move_coil(bit on, bit [NOW_W-1:0] now);
    if (coil_main != on) begin
      start_ms  = now;
      coil_main = on;
    end
  endfunction

  function void take_command_word(bit cmd_valid, logic [CMD_W-1:0] cmd, bit fb1, bit fb2,
                                  bit [NOW_W-1:0] now);
    bit          on, agree;
    valve_word_t w;
    on = (cmd != CMD_CLOSE);
    if (cmd_valid) begin
      case (kind) inside
        KIND_ONE_OUT: coil_main = on;
        KIND_TWO_OUT: begin
          coil_main   = !on;
          coil_second = on;
        end
        KIND_OUT_FB, KIND_OUT_2FB: move_coil(on, now);
        KIND_2OUT_2FB: begin
          if (on && !coil_second) begin
            start_ms    = now;
            coil_main   = 1'b0;
            coil_second = 1'b1;
          end else if (!on && !coil_main) begin
            start_ms    = now;
            coil_main   = 1'b1;
            coil_second = 1'b0;
          end
        end
        KIND_MIXPROOF: begin
          move_coil(cmd == CMD_OPEN, now);
          seat_upper = (cmd == CMD_UPPER);
          seat_lower = (cmd == CMD_LOWER);
        end
        default: ;
      endcase
    end

    case (kind) inside
      KIND_ONE_OUT: w.state = position(coil_main);
      KIND_TWO_OUT: w.state = (coil_main == coil_second) ? ST_FAULT : position(coil_second);
      KIND_OUT_FB: begin
        agree = polarity ? (fb1 == coil_main) : (fb1 != coil_main);
        if (agree) begin
          start_ms = now;
          w.state  = position(coil_main);
        end else begin
          // still travelling: show where the switch says the valve is
          w.state = expired(now) ? ST_FAULT : position(!coil_main);
        end
      end
      KIND_OUT_2FB, KIND_MIXPROOF: begin
        agree = coil_main ? (!fb1 && fb2) : (fb1 && !fb2);
        if (agree) begin
          start_ms = now;
          if (kind == KIND_MIXPROOF && !coil_main && seat_upper)      w.state = ST_UPPER;
          else if (kind == KIND_MIXPROOF && !coil_main && seat_lower) w.state = ST_LOWER;
          else w.state = position(coil_main);
        end else begin
          w.state = expired(now) ? ST_FAULT : position(coil_main);
        end
      end
      KIND_2OUT_2FB: begin
        agree = (fb1 == coil_main) && (fb2 == coil_second);
        if (agree) begin
          start_ms = now;
          w.state  = position(coil_second);
        end else begin
          w.state = expired(now) ? ST_FAULT : position(coil_second);
        end
      end
      default: w.state = ST_CLOSED;
    endcase

    w.drive_main   = (kind <= KIND_MIXPROOF) && coil_main;
    w.drive_second = (kind == KIND_TWO_OUT || kind == KIND_2OUT_2FB) && coil_second;
    w.drive_upper  = (kind == KIND_MIXPROOF) && seat_upper;
    w.drive_lower  = (kind == KIND_MIXPROOF) && seat_lower;
    due_words.push_back(w);
    words_taken++;
  endfunction

  task flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch at result %0d, %s: got %0h, expected %0h",
             results_checked, field, got, want);
    errors++;
  endtask

  task match_result(logic [STATE_W-1:0] state, logic dm, logic ds, logic du, logic dl);
    valve_word_t want;
    if (due_words.size() == 0) begin
      flag_mismatch("word with none due", 32'(state), 32'd0);
      return;
    end
    want = due_words.pop_front();
    results_checked++;
    if (want.state == ST_FAULT) faults_seen++;
    if (state !== want.state)
      flag_mismatch("valve_state", 32'(state), 32'(want.state));
    if (dm !== want.drive_main)
      flag_mismatch("drive_main", 32'(dm), 32'(want.drive_main));
    if (ds !== want.drive_second)
      flag_mismatch("drive_second", 32'(ds), 32'(want.drive_second));
    if (du !== want.drive_upper)
      flag_mismatch("drive_upper", 32'(du), 32'(want.drive_upper));
    if (dl !== want.drive_lower)
      flag_mismatch("drive_lower", 32'(dl), 32'(want.drive_lower));
  endtask
endclass

module tb_valve_feedback_supervisor_core
  import vfs_pkg::*;
();

  localparam logic [KIND_W-1:0] KIND_UNUSED_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED_B = 3'd7;
  localparam int IDLE_LIMIT = 1000;
  localparam int STALL_CYCLES = 120;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid, in_ready;
  logic                  in_cmd_valid;
  logic [CMD_W-1:0]      in_cmd;
  logic                  in_fb_first, in_fb_second;
  logic [NOW_W-1:0]      in_now_ms;
  logic                  out_valid, out_ready;
  logic [STATE_W-1:0]    out_valve_state;
  logic                  out_drive_main, out_drive_second, out_drive_upper, out_drive_lower;

  valve_shadow    sb = new();
  bit [NOW_W-1:0] clock_ms;
  bit             sender_tight;
  bit             stall_done;
  int             reg_writes;
  int             idle_cycles;

  valve_feedback_supervisor_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd_valid     (in_cmd_valid),
    .in_cmd           (in_cmd),
    .in_fb_first      (in_fb_first),
    .in_fb_second     (in_fb_second),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_valve_state  (out_valve_state),
    .out_drive_main   (out_drive_main),
    .out_drive_second (out_drive_second),
    .out_drive_upper  (out_drive_upper),
    .out_drive_lower  (out_drive_lower)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // note accepted words first so a result shown in the same cycle as its word would still find its entry
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.take_command_word(in_cmd_valid, in_cmd, in_fb_first, in_fb_second, in_now_ms);
      if (out_valid && out_ready)
        sb.match_result(out_valve_state, out_drive_main, out_drive_second,
                        out_drive_upper, out_drive_lower);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("tb_valve_feedback_supervisor_core: FAIL");
        $finish;
      end
    end
  end

  // receiver: random ready pattern, one long stall to back up the input side
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!stall_done && sb.results_checked >= 600) begin
        stall_done = 1'b1;
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
      end
      n = pick_gap();
      if (n > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
      n = $urandom_range(1, 24);
      @(negedge clk);
      out_ready <= 1'b1;
      repeat (n - 1) @(negedge clk);
    end
  end

  task automatic send_word(bit cv, logic [CMD_W-1:0] cmd, bit f1, bit f2,
                           logic [NOW_W-1:0] now);
    int gap;
    gap = sender_tight ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd_valid <= cv;
    in_cmd       <= cmd;
    in_fb_first  <= f1;
    in_fb_second <= f2;
    in_now_ms    <= now;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_word();
    bit               cv, f1, f2;
    logic [CMD_W-1:0] cmd;
    int               r;
    r = $urandom_range(0, 99);
    if (r < 50)      clock_ms += $urandom_range(0, 3);
    else if (r < 85) clock_ms += $urandom_range(0, sb.switch_ms + sb.switch_ms / 2 + 2);
    else if (r < 97) clock_ms += sb.switch_ms + $urandom_range(0, 1);
    else             clock_ms = $urandom;
    cv  = ($urandom_range(0, 9) < 3);
    cmd = CMD_W'($urandom_range(0, 3));
    if ($urandom_range(0, 9) < 6) begin
      // feedback that follows the drive
      case (sb.kind)
        KIND_OUT_FB: begin
          f1 = sb.polarity ? sb.coil_main : !sb.coil_main;
          f2 = 1'($urandom_range(0, 1));
        end
        KIND_2OUT_2FB: begin
          f1 = sb.coil_main;
          f2 = sb.coil_second;
        end
        default: begin
          f1 = !sb.coil_main;
          f2 = sb.coil_main;
        end
      endcase
    end else begin
      f1 = 1'($urandom_range(0, 1));
      f2 = 1'($urandom_range(0, 1));
    end
    send_word(cv, cmd, f1, f2, clock_ms);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.due_words.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
    reg_writes++;
  endtask

  initial begin
    logic [KIND_W-1:0]     kind_sel;
    logic [CFG_DATA_W-1:0] sw_sel;
    int                    n;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_VALVE_KIND;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_cmd_valid = 1'b0;
    in_cmd       = CMD_CLOSE;
    in_fb_first  = 1'b0;
    in_fb_second = 1'b0;
    in_now_ms    = '0;
    sender_tight = 1'b0;
    reg_writes   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: one output, inverted feedback, 1000 ms
    send_word(1'b0, CMD_CLOSE, 1'b0, 1'b0, 32'h0000_0000);
    send_word(1'b1, CMD_OPEN,  1'b1, 1'b1, 32'hFFFF_FFFF);
    send_word(1'b1, CMD_UPPER, 1'b0, 1'b1, 32'h8000_0000);
    send_word(1'b1, CMD_LOWER, 1'b1, 1'b0, 32'h7FFF_FFFF);
    send_word(1'b1, CMD_CLOSE, 1'b0, 1'b0, 32'h0000_0001);
    drain();
    // two coils both off after reset read as fault until commanded
    set_reg(CFG_VALVE_KIND, KIND_TWO_OUT);
    send_word(1'b0, CMD_OPEN,  1'b0, 1'b0, 32'd10);
    send_word(1'b1, CMD_CLOSE, 1'b0, 1'b0, 32'd11);
    send_word(1'b1, CMD_OPEN,  1'b0, 1'b0, 32'd12);
    drain();
    // single feedback with default polarity and timeout: edge of the timeout
    set_reg(CFG_VALVE_KIND, KIND_OUT_FB);
    send_word(1'b1, CMD_OPEN,  1'b1, 1'b0, 32'd5000);
    send_word(1'b0, CMD_CLOSE, 1'b1, 1'b0, 32'd6000);
    send_word(1'b0, CMD_CLOSE, 1'b1, 1'b0, 32'd6001);
    drain();
    set_reg(CFG_FB_POLARITY, 16'd1);
    set_reg(CFG_SWITCH_TIME, 16'd0);
    send_word(1'b1, CMD_CLOSE, 1'b1, 1'b0, 32'hFFFF_FFF0);
    send_word(1'b0, CMD_CLOSE, 1'b1, 1'b0, 32'hFFFF_FFF1);
    send_word(1'b0, CMD_OPEN,  1'b0, 1'b0, 32'h0000_0005);
    drain();
    // timeout measured across the timestamp wrap
    set_reg(CFG_FB_POLARITY, 16'd0);
    set_reg(CFG_SWITCH_TIME, 16'hFFFF);
    send_word(1'b1, CMD_OPEN, 1'b1, 1'b1, 32'hFFFF_FFF0);
    send_word(1'b0, CMD_OPEN, 1'b1, 1'b1, 32'h0000_FFEF);
    send_word(1'b0, CMD_OPEN, 1'b1, 1'b1, 32'h0000_FFF0);
    drain();
    set_reg(CFG_VALVE_KIND, KIND_OUT_2FB);
    send_word(1'b1, CMD_OPEN,  1'b0, 1'b1, 32'd100);
    send_word(1'b1, CMD_CLOSE, 1'b1, 1'b1, 32'd200);
    send_word(1'b0, CMD_CLOSE, 1'b1, 1'b0, 32'd300);
    drain();
    set_reg(CFG_VALVE_KIND, KIND_2OUT_2FB);
    send_word(1'b1, CMD_OPEN,  1'b0, 1'b1, 32'd400);
    send_word(1'b1, CMD_CLOSE, 1'b1, 1'b1, 32'd500);
    send_word(1'b0, CMD_OPEN,  1'b1, 1'b0, 32'd600);
    drain();
    set_reg(CFG_VALVE_KIND, KIND_MIXPROOF);
    set_reg(CFG_SWITCH_TIME, SWITCH_TIME_RST);
    send_word(1'b1, CMD_UPPER, 1'b1, 1'b0, 32'd700);
    send_word(1'b1, CMD_LOWER, 1'b1, 1'b0, 32'd800);
    send_word(1'b1, CMD_OPEN,  1'b0, 1'b1, 32'd900);
    send_word(1'b0, CMD_OPEN,  1'b0, 1'b0, 32'd2000);
    drain();
    // unused kind codes: commands ignored, outputs quiet
    set_reg(CFG_VALVE_KIND, KIND_UNUSED_A);
    send_word(1'b1, CMD_OPEN, 1'b1, 1'b1, 32'd3000);
    drain();
    set_reg(CFG_VALVE_KIND, KIND_UNUSED_B);
    send_word(1'b1, CMD_CLOSE, 1'b0, 1'b1, 32'd3001);

    clock_ms = $urandom;
    for (int ph = 0; ph < 12; ph++) begin
      kind_sel = (ph < 8) ? ph[KIND_W-1:0] : KIND_W'($urandom_range(0, 5));
      case ($urandom_range(0, 5))
        0:       sw_sel = 16'd0;
        1:       sw_sel = 16'hFFFF;
        2:       sw_sel = CFG_DATA_W'($urandom_range(1, 40));
        3:       sw_sel = SWITCH_TIME_RST;
        default: sw_sel = CFG_DATA_W'($urandom_range(0, 65535));
      endcase
      drain();
      set_reg(CFG_VALVE_KIND, kind_sel);
      set_reg(CFG_FB_POLARITY, CFG_DATA_W'($urandom_range(0, 1)));
      set_reg(CFG_SWITCH_TIME, sw_sel);
      if ($urandom_range(0, 2) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
      sender_tight = ($urandom_range(0, 3) == 0);
      n = (kind_sel > KIND_MIXPROOF) ? 40 : 180;
      repeat (n) send_random_word();
    end

    drain();
    repeat (4) @(posedge clk);
    $display("covered %0d words over %0d register writes and all kind codes, %0d fault reports",
             sb.words_taken, reg_writes, sb.faults_seen);
    $display("long output stall %0s, %0d mismatches",
             stall_done ? "applied" : "not reached", sb.errors);
    if (sb.errors == 0 && sb.due_words.size() == 0) begin
      $display("tb_valve_feedback_supervisor_core: PASS");
    end else begin
      $display("tb_valve_feedback_supervisor_core: FAIL");
    end
    $finish;
  end
endmodule
